FILE: design/aligned_block_transfer_planner_assert.svh
// Assertion macros shared by the checker of the transfer planner.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ALIGNED_BLOCK_TRANSFER_PLANNER_ASSERT_SVH
`define ALIGNED_BLOCK_TRANSFER_PLANNER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ABTP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("planner check failed");

// Next-cycle implication, disabled during reset.
`define ABTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("planner check failed");

`endif

FILE: design/abtp_pkg.sv
// Shared types and constants of the aligned block transfer planner.
// Depends on nothing; used by the top level and its checker.
package abtp_pkg;

    localparam int OFFSET_W = 48;
    localparam int COUNT_W  = 21;
    localparam int KIND_W   = 2;
    localparam int BOUNCE_W = 16;
    localparam int CALLER_W = 20;
    localparam int COPY_W   = 17;

    // Items per request, terminal item included.
    localparam int RESULT_LIMIT = 21;
    localparam int ITEM_CNT_W   = $clog2(RESULT_LIMIT + 1);

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    localparam logic OPC_READ  = 1'b0;
    localparam logic OPC_WRITE = 1'b1;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_MODE     = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PASS,
        S_CALC,
        S_CHK,
        S_CLIP,
        S_RD,
        S_COMB,
        S_HEAD,
        S_TAIL,
        S_WR,
        S_TERM
    } state_t;

endpackage

FILE: design/aligned_block_transfer_planner.sv
// Aligned block transfer planner: splits a byte request into aligned device operations.
// An accepted request goes through S_CALC and S_CHK (and S_CLIP for a clipped read)
// before its first word; pass-through and zero-length requests go straight to S_PASS or
// S_TERM. Each chunk repeats this setup before its words. The block takes one request at
// a time and holds req_stall until its terminal word is loaded; item_stall holds words.
// Reset (rst_n low, asynchronous): capacity 0, aligned mode on, sequencer idle.
module aligned_block_transfer_planner #(
    parameter int ALIGN_BYTES       = 4096,
    parameter int BOUNCE_BYTES      = 65536,
    parameter int MAX_REQUEST_BYTES = 1048576
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [abtp_pkg::OFFSET_W-1:0]     cfg_data,
    // requests
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              opcode,
    input  logic [abtp_pkg::OFFSET_W-1:0]     byte_offset,
    input  logic [abtp_pkg::COUNT_W-1:0]      byte_count,
    // device operations
    output logic                              item_valid,
    input  logic                              item_stall,
    output logic [abtp_pkg::KIND_W-1:0]       op_kind,
    output logic [abtp_pkg::OFFSET_W-1:0]     device_offset,
    output logic [abtp_pkg::COUNT_W-1:0]      span_bytes,
    output logic [abtp_pkg::BOUNCE_W-1:0]     bounce_offset,
    output logic [abtp_pkg::CALLER_W-1:0]     caller_offset,
    output logic [abtp_pkg::COPY_W-1:0]       copy_bytes,
    output logic                              status,
    output logic                              last
);
    import abtp_pkg::*;

    localparam int ALIGN_LG = $clog2(ALIGN_BYTES);
    localparam int LEN_W    = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int CHUNK_W  = $clog2(BOUNCE_BYTES + 2 * ALIGN_BYTES + 1);
    localparam int OFF_W    = OFFSET_W + 1;
    localparam int END_W    = OFFSET_W + 2;

    localparam logic [CHUNK_W-1:0] ALIGN_C  = CHUNK_W'(ALIGN_BYTES);
    localparam logic [CHUNK_W-1:0] AMASK_C  = CHUNK_W'(ALIGN_BYTES - 1);
    localparam logic [CHUNK_W-1:0] BOUNCE_C = CHUNK_W'(BOUNCE_BYTES);

    state_t state_reg, state_next;

    logic [OFFSET_W-1:0]   capacity_reg;
    logic                  mode_reg;
    logic                  item_valid_reg, item_valid_next;
    logic [ITEM_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  err_reg, err_next;

    logic                  op_reg, op_next;
    logic [OFF_W-1:0]      off_reg, off_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      done_reg, done_next;
    logic [CHUNK_W-1:0]    want_reg, want_next;
    logic [CHUNK_W-1:0]    sum_reg, sum_next;
    logic [CHUNK_W-1:0]    span_reg, span_next;
    logic                  skip_nz_reg, skip_nz_next;
    logic                  tail_nz_reg, tail_nz_next;

    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [OFFSET_W-1:0]   dev_reg, dev_next;
    logic [COUNT_W-1:0]    spanout_reg, spanout_next;
    logic [BOUNCE_W-1:0]   bpos_reg, bpos_next;
    logic [CALLER_W-1:0]   cpos_reg, cpos_next;
    logic [COPY_W-1:0]     copy_reg, copy_next;
    logic                  status_reg, status_next;
    logic                  last_reg, last_next;

    logic [OFF_W-1:0]      base;
    logic [ALIGN_LG-1:0]   skip;
    logic [CHUNK_W-1:0]    room;
    logic [CHUNK_W-1:0]    want_c;
    logic [CHUNK_W-1:0]    sum_c;
    logic [END_W-1:0]      chunk_end;
    logic [OFFSET_W-1:0]   cap_diff;
    logic [CHUNK_W-1:0]    lastblk;
    logic [LEN_W-1:0]      len_in;
    logic [LEN_W-1:0]      len_left;
    logic                  can_load;
    logic                  budget_out;

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);

    assign item_valid    = item_valid_reg;
    assign op_kind       = kind_reg;
    assign device_offset = dev_reg;
    assign span_bytes    = spanout_reg;
    assign bounce_offset = bpos_reg;
    assign caller_offset = cpos_reg;
    assign copy_bytes    = copy_reg;
    assign status        = status_reg;
    assign last          = last_reg;

    // Chunk geometry, taken from the current running offset and the remaining length.
    assign base   = {off_reg[OFF_W-1:ALIGN_LG], {ALIGN_LG{1'b0}}};
    assign skip   = off_reg[ALIGN_LG-1:0];
    assign room   = BOUNCE_C - CHUNK_W'(skip);
    assign want_c = (32'(len_reg) < 32'(room)) ? CHUNK_W'(len_reg) : room;
    assign sum_c  = CHUNK_W'(skip) + want_c;

    assign chunk_end = END_W'(base) + END_W'(span_reg);
    assign cap_diff  = capacity_reg - base[OFFSET_W-1:0];
    assign lastblk   = span_reg - ALIGN_C;
    assign len_left  = len_reg - LEN_W'(want_reg);

    assign len_in = (32'(byte_count) > 32'(MAX_REQUEST_BYTES)) ?
                    LEN_W'(MAX_REQUEST_BYTES) : LEN_W'(byte_count);

    assign can_load   = !item_valid_reg || !item_stall;
    assign budget_out = (cnt_reg >= ITEM_CNT_W'(RESULT_LIMIT - 1));

    always_comb
    begin
        state_next      = state_reg;
        item_valid_next = item_valid_reg && item_stall;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        op_next         = op_reg;
        off_next        = off_reg;
        len_next        = len_reg;
        done_next       = done_reg;
        want_next       = want_reg;
        sum_next        = sum_reg;
        span_next       = span_reg;
        skip_nz_next    = skip_nz_reg;
        tail_nz_next    = tail_nz_reg;
        kind_next       = kind_reg;
        dev_next        = dev_reg;
        spanout_next    = spanout_reg;
        bpos_next       = bpos_reg;
        cpos_next       = cpos_reg;
        copy_next       = copy_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = opcode;
                    off_next  = {1'b0, byte_offset};
                    len_next  = len_in;
                    done_next = '0;
                    cnt_next  = '0;
                    err_next  = 1'b0;
                    if (len_in == '0)
                        state_next = S_TERM;
                    else if (!mode_reg)
                        state_next = S_PASS;
                    else
                        state_next = S_CALC;
                end
            end
            S_PASS:
            begin
                if (can_load)
                begin
                    item_valid_next = 1'b1;
                    kind_next       = op_reg ? KIND_WRITE : KIND_READ;
                    dev_next        = off_reg[OFFSET_W-1:0];
                    spanout_next    = COUNT_W'(len_reg);
                    bpos_next       = '0;
                    cpos_next       = '0;
                    copy_next       = '0;
                    status_next     = 1'b0;
                    last_next       = 1'b0;
                    cnt_next        = cnt_reg + ITEM_CNT_W'(1);
                    state_next      = S_TERM;
                end
            end
            S_CALC:
            begin
                if (32'(skip) >= 32'(BOUNCE_BYTES))
                begin
                    err_next   = 1'b1;
                    state_next = S_TERM;
                end
                else
                begin
                    want_next    = want_c;
                    sum_next     = sum_c;
                    span_next    = (sum_c + AMASK_C) & ~AMASK_C;
                    skip_nz_next = (skip != '0);
                    tail_nz_next = ((sum_c & AMASK_C) != '0);
                    state_next   = S_CHK;
                end
            end
            S_CHK:
            begin
                if (op_reg == OPC_READ)
                    state_next = (chunk_end > END_W'(capacity_reg)) ? S_CLIP : S_RD;
                else if (chunk_end > END_W'(capacity_reg))
                begin
                    err_next   = 1'b1;
                    state_next = S_TERM;
                end
                else if (skip_nz_reg && tail_nz_reg && span_reg == (ALIGN_C << 1))
                    state_next = S_COMB;
                else if (skip_nz_reg)
                    state_next = S_HEAD;
                else if (tail_nz_reg)
                    state_next = S_TAIL;
                else
                    state_next = S_WR;
            end
            S_CLIP:
            begin
                // The clipped span is below the aligned span, so it fits a chunk.
                if (base >= {1'b0, capacity_reg} || CHUNK_W'(cap_diff) < sum_reg)
                begin
                    err_next   = 1'b1;
                    state_next = S_TERM;
                end
                else
                begin
                    span_next  = CHUNK_W'(cap_diff);
                    state_next = S_RD;
                end
            end
            S_RD, S_WR:
            begin
                if (can_load)
                begin
                    if (budget_out)
                    begin
                        err_next   = 1'b1;
                        state_next = S_TERM;
                    end
                    else
                    begin
                        item_valid_next = 1'b1;
                        kind_next    = (state_reg == S_WR) ? KIND_WRITE : KIND_READ;
                        dev_next     = base[OFFSET_W-1:0];
                        spanout_next = COUNT_W'(span_reg);
                        bpos_next    = '0;
                        cpos_next    = CALLER_W'(done_reg);
                        copy_next    = COPY_W'(want_reg);
                        status_next  = 1'b0;
                        last_next    = 1'b0;
                        cnt_next     = cnt_reg + ITEM_CNT_W'(1);
                        off_next     = off_reg + OFF_W'(want_reg);
                        len_next     = len_left;
                        done_next    = done_reg + LEN_W'(want_reg);
                        state_next   = (len_left == '0) ? S_TERM : S_CALC;
                    end
                end
            end
            S_COMB, S_HEAD, S_TAIL:
            begin
                if (can_load)
                begin
                    if (budget_out)
                    begin
                        err_next   = 1'b1;
                        state_next = S_TERM;
                    end
                    else
                    begin
                        item_valid_next = 1'b1;
                        kind_next    = KIND_READ;
                        dev_next     = base[OFFSET_W-1:0];
                        spanout_next = COUNT_W'(ALIGN_C);
                        bpos_next    = '0;
                        cpos_next    = '0;
                        copy_next    = '0;
                        status_next  = 1'b0;
                        last_next    = 1'b0;
                        cnt_next     = cnt_reg + ITEM_CNT_W'(1);
                        state_next   = S_WR;
                        if (state_reg == S_COMB)
                            spanout_next = COUNT_W'(span_reg);
                        else if (state_reg == S_TAIL)
                        begin
                            dev_next  = OFFSET_W'(base + OFF_W'(lastblk));
                            bpos_next = BOUNCE_W'(lastblk);
                        end
                        else if (tail_nz_reg && lastblk != '0)
                            state_next = S_TAIL;
                    end
                end
            end
            S_TERM:
            begin
                if (can_load)
                begin
                    item_valid_next = 1'b1;
                    kind_next    = KIND_END;
                    dev_next     = '0;
                    spanout_next = '0;
                    bpos_next    = '0;
                    cpos_next    = '0;
                    copy_next    = '0;
                    status_next  = err_reg;
                    last_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= '0;
            mode_reg       <= 1'b1;
            item_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            err_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CAPACITY)
                    capacity_reg <= cfg_data;
                else
                    mode_reg <= cfg_data[0];
            end
            item_valid_reg <= item_valid_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        off_reg     <= off_next;
        len_reg     <= len_next;
        done_reg    <= done_next;
        want_reg    <= want_next;
        sum_reg     <= sum_next;
        span_reg    <= span_next;
        skip_nz_reg <= skip_nz_next;
        tail_nz_reg <= tail_nz_next;
        kind_reg    <= kind_next;
        dev_reg     <= dev_next;
        spanout_reg <= spanout_next;
        bpos_reg    <= bpos_next;
        cpos_reg    <= cpos_next;
        copy_reg    <= copy_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

endmodule

FILE: design/abtp_checker.sv
// Port-level checker for the aligned block transfer planner, bound to the top level.
// Depends on abtp_pkg and aligned_block_transfer_planner_assert.svh.
`include "aligned_block_transfer_planner_assert.svh"

module abtp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_stall,
    input logic                              item_valid,
    input logic [abtp_pkg::KIND_W-1:0]       op_kind,
    input logic [abtp_pkg::OFFSET_W-1:0]     device_offset,
    input logic [abtp_pkg::COUNT_W-1:0]      span_bytes,
    input logic [abtp_pkg::COPY_W-1:0]       copy_bytes,
    input logic                              status,
    input logic                              last
);
    import abtp_pkg::*;

    // A request keeps the planner busy at least until its terminal word.
    `ABTP_ASSERT_NEXT(busy_after_accept, req_valid && !req_stall, req_stall)

    // While a non-final word is shown, the request is still in progress.
    `ABTP_ASSERT_NOW(busy_while_ops, item_valid && !last, req_stall)

    // The final word is the terminal kind and carries no transfer.
    `ABTP_ASSERT_NOW(last_is_end, item_valid && last, op_kind == KIND_END && device_offset == '0 && span_bytes == '0 && copy_bytes == '0)

    // Device operations are never final and never flag an error.
    `ABTP_ASSERT_NOW(ops_ok, item_valid && op_kind != KIND_END, !last && !status)

endmodule

bind aligned_block_transfer_planner abtp_checker u_abtp_checker (.*);

FILE: tb/aligned_block_transfer_planner_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for aligned_block_transfer_planner: predicts every device word
// of each request and compares it with the block's output. Depends on abtp_pkg and the DUT.
module aligned_block_transfer_planner_tb;

    import abtp_pkg::*;

    localparam int ALIGN_BYTES       = 4096;
    localparam int BOUNCE_BYTES      = 65536;
    localparam int MAX_REQUEST_BYTES = 1048576;
    localparam longint CYCLE_LIMIT   = 600000;
    localparam logic [OFFSET_W-1:0] CAP_4M   = 48'h40_0000;
    localparam logic [OFFSET_W-1:0] CAP_FULL = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] dev_off;
        logic [COUNT_W-1:0]  span;
        logic [BOUNCE_W-1:0] bounce_off;
        logic [CALLER_W-1:0] caller_off;
        logic [COPY_W-1:0]   copy_len;
        logic                err;
        logic                fin;
    } plan_op_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [OFFSET_W-1:0] cfg_data;
    logic                req_valid;
    logic                req_stall;
    logic                opcode;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  byte_count;
    logic                item_valid;
    logic                item_stall;
    logic [KIND_W-1:0]   op_kind;
    logic [OFFSET_W-1:0] device_offset;
    logic [COUNT_W-1:0]  span_bytes;
    logic [BOUNCE_W-1:0] bounce_offset;
    logic [CALLER_W-1:0] caller_offset;
    logic [COPY_W-1:0]   copy_bytes;
    logic                status;
    logic                last;

    // Register mirrors, at their reset values.
    logic [OFFSET_W-1:0] cap_now  = '0;
    logic                mode_now = 1'b1;

    plan_op_t expected_ops[$];
    int       plan_count;
    bit       plan_over;
    int       error_count = 0;
    longint   cycle_count = 0;
    bit       gaps_on = 1'b1;
    bit       hold_start = 1'b0;
    int       hold_left = 0;
    int       sink_wait = 0;

    aligned_block_transfer_planner #(
        .ALIGN_BYTES       (ALIGN_BYTES),
        .BOUNCE_BYTES      (BOUNCE_BYTES),
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .opcode        (opcode),
        .byte_offset   (byte_offset),
        .byte_count    (byte_count),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op_kind       (op_kind),
        .device_offset (device_offset),
        .span_bytes    (span_bytes),
        .bounce_offset (bounce_offset),
        .caller_offset (caller_offset),
        .copy_bytes    (copy_bytes),
        .status        (status),
        .last          (last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Long output hold-off, counted down here so the request side keeps running.
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= 400;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    function automatic logic [OFFSET_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[OFFSET_W-1:0];
    endfunction

    function automatic string op_text(input plan_op_t op);
        return $sformatf("kind %0d dev %h span %0d bounce %0d caller %0d copy %0d status %0d last %0d",
                         op.kind, op.dev_off, op.span, op.bounce_off, op.caller_off,
                         op.copy_len, op.err, op.fin);
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Appends one device word; a non-final word that would leave no slot for the
    // terminal word is dropped and flags the request as over budget.
    function automatic void push_op(input logic [KIND_W-1:0] kind, input logic [63:0] dev,
                                    input logic [63:0] span, input logic [63:0] bpos,
                                    input logic [63:0] cpos, input logic [63:0] copy,
                                    input logic err, input logic fin);
        plan_op_t op;
        if (!fin && plan_count >= RESULT_LIMIT - 1)
        begin
            plan_over = 1'b1;
            return;
        end
        if (plan_count >= RESULT_LIMIT)
            return;
        op.kind       = kind;
        op.dev_off    = dev[OFFSET_W-1:0];
        op.span       = span[COUNT_W-1:0];
        op.bounce_off = bpos[BOUNCE_W-1:0];
        op.caller_off = cpos[CALLER_W-1:0];
        op.copy_len   = copy[COPY_W-1:0];
        op.err        = err;
        op.fin        = fin;
        expected_ops.push_back(op);
        plan_count++;
    endfunction

    function automatic void plan_request(input logic opc, input logic [OFFSET_W-1:0] off_in,
                                         input logic [COUNT_W-1:0] cnt_in);
        logic [63:0] a_sz, a_mask, b_sz, off, len, done, base, skip, want, span, tail, lastblk;
        logic        failed;
        a_sz       = 64'(ALIGN_BYTES);
        a_mask     = ~(a_sz - 1);
        b_sz       = 64'(BOUNCE_BYTES);
        off        = 64'(off_in);
        len        = 64'(cnt_in);
        done       = '0;
        failed     = 1'b0;
        plan_count = 0;
        plan_over  = 1'b0;
        if (len > 64'(MAX_REQUEST_BYTES))
            len = 64'(MAX_REQUEST_BYTES);
        if (len != 0 && !mode_now)
        begin
            push_op((opc == OPC_WRITE) ? KIND_WRITE : KIND_READ, off, len, 0, 0, 0, 1'b0, 1'b0);
            len = 0;
        end
        while (len != 0)
        begin
            base = off & a_mask;
            skip = off - base;
            if (skip >= b_sz)
            begin
                failed = 1'b1;
                break;
            end
            want = (len < b_sz - skip) ? len : b_sz - skip;
            span = (skip + want + a_sz - 1) & a_mask;
            if (opc == OPC_READ)
            begin
                if (base + span > 64'(cap_now))
                begin
                    if (base >= 64'(cap_now))
                    begin
                        failed = 1'b1;
                        break;
                    end
                    span = 64'(cap_now) - base;
                    if (span < skip + want)
                    begin
                        failed = 1'b1;
                        break;
                    end
                end
                push_op(KIND_READ, base, span, 0, done, want, 1'b0, 1'b0);
            end
            else
            begin
                if (base + span > 64'(cap_now))
                begin
                    failed = 1'b1;
                    break;
                end
                tail = (skip + want) & (a_sz - 1);
                // Partial head and tail in two adjacent blocks are read back together.
                if (skip != 0 && tail != 0 && span == 2 * a_sz)
                    push_op(KIND_READ, base, span, 0, 0, 0, 1'b0, 1'b0);
                else
                begin
                    if (skip != 0)
                        push_op(KIND_READ, base, a_sz, 0, 0, 0, 1'b0, 1'b0);
                    if (tail != 0)
                    begin
                        lastblk = span - a_sz;
                        if (!(skip != 0 && lastblk == 0))
                            push_op(KIND_READ, base + lastblk, a_sz, lastblk, 0, 0, 1'b0, 1'b0);
                    end
                end
                push_op(KIND_WRITE, base, span, 0, done, want, 1'b0, 1'b0);
            end
            if (plan_over)
            begin
                failed = 1'b1;
                break;
            end
            off  = off + want;
            len  = len - want;
            done = done + want;
        end
        if (plan_over)
            failed = 1'b1;
        push_op(KIND_END, 0, 0, 0, 0, 0, failed, 1'b1);
    endfunction

    function automatic void check_op(input plan_op_t got);
        plan_op_t want_op;
        if (expected_ops.size() == 0)
        begin
            note_error({"word with nothing expected: ", op_text(got)});
            return;
        end
        want_op = expected_ops.pop_front();
        if (got.kind !== want_op.kind || got.dev_off !== want_op.dev_off ||
            got.span !== want_op.span || got.bounce_off !== want_op.bounce_off ||
            got.caller_off !== want_op.caller_off || got.copy_len !== want_op.copy_len ||
            got.err !== want_op.err || got.fin !== want_op.fin)
            note_error({"mismatch: expected ", op_text(want_op), " got ", op_text(got)});
    endfunction

    initial
    begin : result_sink
        plan_op_t got;
        item_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && item_valid && !item_stall)
            begin
                got = '{op_kind, device_offset, span_bytes, bounce_offset, caller_offset,
                        copy_bytes, status, last};
                check_op(got);
                sink_wait = gaps_on ? $urandom_range(0, 19) : 0;
            end
            if (hold_left != 0 || sink_wait != 0)
                item_stall <= 1'b1;
            else
                item_stall <= 1'b0;
            if (hold_left == 0 && sink_wait != 0)
                sink_wait--;
        end
    end

    // Writes both registers back to back; only called while the block is idle.
    task automatic configure(input logic [OFFSET_W-1:0] cap, input logic mode);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_now   = cap;
        cfg_index <= CFG_MODE;
        cfg_data  <= {{(OFFSET_W-1){1'b0}}, mode};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_now  = mode;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input logic opc, input logic [OFFSET_W-1:0] off,
                                input logic [COUNT_W-1:0] cnt);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        opcode      <= opc;
        byte_offset <= off;
        byte_count  <= cnt;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        plan_request(opc, off, cnt);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (expected_ops.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(input logic [OFFSET_W-1:0] cap);
        logic [63:0]        off;
        logic [COUNT_W-1:0] cnt;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            cnt = COUNT_W'($urandom_range(1, 8192));
        else if (pick < 75)
            cnt = COUNT_W'($urandom_range(1, 70000));
        else if (pick < 88)
            cnt = COUNT_W'($urandom_range(70001, 300000));
        else if (pick < 96)
            cnt = COUNT_W'($urandom_range(300001, 2097151));
        else
            cnt = '0;
        pick = $urandom_range(0, 99);
        if (cap == 0 || pick >= 80)
            off = 64'(rand48());
        else if (pick < 65)
        begin
            // Mostly starts inside the store, often aligned or just short of a boundary.
            off  = 64'(rand48()) % 64'(cap);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                off = off & ~64'(ALIGN_BYTES - 1);
            else if (pick < 6)
                off = (off | 64'(ALIGN_BYTES - 1)) - 64'($urandom_range(0, 200));
        end
        else if (cap > 300000)
            off = 64'(cap) - 64'($urandom_range(0, 300000));
        else
            off = 64'(rand48()) % 64'(cap);
        send_request(($urandom_range(0, 1) == 0) ? OPC_READ : OPC_WRITE, off[OFFSET_W-1:0], cnt);
    endtask

    task automatic test_reset_values();
        send_request(OPC_READ, 48'd0, 21'd0);
        send_request(OPC_READ, 48'd0, 21'd100);
        send_request(OPC_WRITE, 48'd0, 21'd4096);
        wait_for_results();
    endtask

    task automatic test_aligned_split();
        configure(CAP_4M, 1'b1);
        send_request(OPC_WRITE, 48'd0, 21'd0);
        send_request(OPC_READ, 48'd0, 21'd4096);
        send_request(OPC_WRITE, 48'd4000, 21'd200);
        send_request(OPC_WRITE, 48'd100, 21'd3996);
        send_request(OPC_WRITE, 48'd0, 21'd5000);
        send_request(OPC_WRITE, 48'd10, 21'd20);
        send_request(OPC_WRITE, 48'd100, 21'd9000);
        send_request(OPC_WRITE, 48'd8192, 21'd65536);
        send_request(OPC_READ, 48'd1000, 21'd200000);
        send_request(OPC_WRITE, 48'd4095, 21'h1F_FFFF);
        wait_for_results();
    endtask

    task automatic test_capacity_limits();
        configure(CAP_4M, 1'b1);
        send_request(OPC_READ, CAP_4M - 48'd100, 21'd1000);
        send_request(OPC_READ, CAP_4M, 21'd10);
        send_request(OPC_READ, CAP_4M - 48'd70000, 21'd100000);
        send_request(OPC_WRITE, CAP_4M - 48'd100, 21'd50);
        send_request(OPC_WRITE, CAP_4M - 48'd150000, 21'd200000);
        wait_for_results();
        // A capacity off the alignment grid lets a read be clipped and still succeed.
        configure(CAP_4M + 48'd1000, 1'b1);
        send_request(OPC_READ, CAP_4M, 21'd500);
        send_request(OPC_READ, CAP_4M - 48'd100, 21'd1100);
        wait_for_results();
        configure(CAP_FULL, 1'b1);
        send_request(OPC_WRITE, 48'hFFFF_FFFF_F000, 21'd4095);
        send_request(OPC_READ, CAP_FULL, 21'd1);
        send_request(OPC_READ, 48'hFFFF_FFFF_E000, 21'd100);
        wait_for_results();
    endtask

    task automatic test_pass_through();
        configure(48'd0, 1'b0);
        send_request(OPC_READ, CAP_FULL, 21'd1);
        send_request(OPC_WRITE, 48'd12345, 21'h1F_FFFF);
        send_request(OPC_WRITE, 48'd0, 21'd0);
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        gaps_on <= 1'b0;
        configure(CAP_4M, 1'b1);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (8)
            send_request(OPC_WRITE, 48'd100, 21'd150000);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count, input logic [OFFSET_W-1:0] cap,
                                       input logic mode, input bit gaps);
        gaps_on <= gaps;
        configure(cap, mode);
        repeat (count)
            send_random(cap);
        wait_for_results();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_CAPACITY;
        cfg_data    = '0;
        req_valid   = 1'b0;
        opcode      = OPC_READ;
        byte_offset = '0;
        byte_count  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_aligned_split();
        test_capacity_limits();
        test_pass_through();
        test_output_backpressure();
        test_random_traffic(30, CAP_FULL - 48'hFFF, 1'b1, 1'b1);
        test_random_traffic(20, rand48() & ~48'(ALIGN_BYTES - 1), 1'b1, 1'b0);
        test_random_traffic(15, rand48(), 1'b0, 1'b1);
        test_random_traffic(20, CAP_FULL, 1'b1, 1'b1);
        test_random_traffic(30, 48'h10_0000, 1'b1, 1'b1);

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/abtp_pkg.sv
design/aligned_block_transfer_planner.sv
design/abtp_checker.sv
tb/aligned_block_transfer_planner_tb.sv
